// ===== src/hfdl_pkg.sv =====
// Shared definitions for the Hermite fractional delay line.
// Default parameter values, fixed field widths, queue status and the back-end state type.
// No dependencies.
package hfdl_pkg;

	localparam int DEF_RING_DEPTH    = 32768;
	localparam int DEF_SAMPLE_BITS   = 24;
	localparam int DEF_FRACTION_BITS = 16;

	// The delay field has a fixed width whatever the ring depth.
	localparam int DELAY_BITS  = 31;
	localparam int QUEUE_DEPTH = 2;

	typedef struct packed {
		logic full;
		logic empty;
	} hfdl_q_status_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_READ,
		BK_DRAIN,
		BK_COEF,
		BK_MUL,
		BK_DONE
	} hfdl_back_state_t;

endpackage

// ===== src/hfdl_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module hfdl_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 32768
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== src/hfdl_front.sv =====
// Front end: accepts input items, saturates the delay and works out the read position.
// Tracks the write index and the ring fill count. Uses hfdl_pkg.
module hfdl_front import hfdl_pkg::*; #(
	parameter int RING_DEPTH    = DEF_RING_DEPTH,
	parameter int SAMPLE_BITS   = DEF_SAMPLE_BITS,
	parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// sample_left, sample_right, delay_q16, zero pad
	input  logic [((2*SAMPLE_BITS+DELAY_BITS+7)/8)*8-1:0] s_tdata,
	output logic q_valid,
	input  logic q_ready,
	// fr, pos0, fill, write index, sample_right, sample_left (lowest first)
	output logic [2*SAMPLE_BITS+3*$clog2(RING_DEPTH)+1+FRACTION_BITS-1:0] q_data
);

	localparam int AB = $clog2(RING_DEPTH);
	localparam int PB = AB + FRACTION_BITS;
	localparam int CW = (PB + 1 > DELAY_BITS) ? PB + 1 : DELAY_BITS + 1;
	localparam logic [CW-1:0] D_ONE = CW'(1) << FRACTION_BITS;
	localparam logic [CW-1:0] D_MAX = CW'(RING_DEPTH - 4) << FRACTION_BITS;

	logic [AB-1:0]          wi_q;
	logic [AB:0]            fill_q;
	logic [DELAY_BITS-1:0]  delay;
	logic [CW-1:0]          d_ext;
	logic [CW-1:0]          d_sat;
	logic [PB-1:0]          pos;
	logic                   accept;

	assign delay  = s_tdata[2*SAMPLE_BITS+DELAY_BITS-1:2*SAMPLE_BITS];
	assign d_ext  = {{(CW-DELAY_BITS){1'b0}}, delay};
	assign accept = s_tvalid && q_ready;

	always_comb begin
		if (d_ext < D_ONE) begin
			d_sat = D_ONE;
		end else if (d_ext > D_MAX) begin
			d_sat = D_MAX;
		end else begin
			d_sat = d_ext;
		end
	end

	// The ring span is a power of two, so the wrap is the natural overflow of PB bits.
	assign pos = {wi_q, {FRACTION_BITS{1'b0}}} - d_sat[PB-1:0];

	assign s_tready = q_ready;
	assign q_valid  = s_tvalid;
	assign q_data   = {s_tdata[SAMPLE_BITS-1:0], s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS],
		wi_q, fill_q, pos[PB-1:FRACTION_BITS], pos[FRACTION_BITS-1:0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wi_q   <= '0;
			fill_q <= '0;
		end else if (accept) begin
			wi_q <= wi_q + AB'(1);
			// Slots are written in index order from zero, so the count tells written from not.
			if (!fill_q[AB]) begin
				fill_q <= fill_q + (AB+1)'(1);
			end
		end
	end

endmodule

// ===== src/hfdl_queue.sv =====
// Short FIFO between the front and back ends of the delay line.
// Uses hfdl_pkg for its depth and status type.
module hfdl_queue import hfdl_pkg::*; #(
	parameter int WIDTH = 8,
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [WIDTH-1:0] in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [WIDTH-1:0] out_data,
	output hfdl_q_status_t   status
);

	localparam int PTR = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PTR-1:0]   wr_q;
	logic [PTR-1:0]   rd_q;
	logic [PTR:0]     count_q;
	logic             push;
	logic             pop;

	assign status.full  = (count_q == (PTR+1)'(DEPTH));
	assign status.empty = (count_q == '0);
	assign in_ready     = !status.full;
	assign out_valid    = !status.empty;
	assign out_data     = slot_q[rd_q];
	assign push         = in_valid && in_ready;
	assign pop          = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PTR'(DEPTH - 1)) ? '0 : wr_q + PTR'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == PTR'(DEPTH - 1)) ? '0 : rd_q + PTR'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (PTR+1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (PTR+1)'(1);
			end
		end
	end

endmodule

// ===== src/hfdl_back.sv =====
// Back end: writes the frame into the rings, reads four neighbours per channel and
// evaluates the Catmull-Rom cubic by Horner steps. Uses hfdl_pkg and hfdl_ram.
module hfdl_back import hfdl_pkg::*; #(
	parameter int RING_DEPTH    = DEF_RING_DEPTH,
	parameter int SAMPLE_BITS   = DEF_SAMPLE_BITS,
	parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
	input  logic clk,
	input  logic arst_n,
	input  logic q_valid,
	output logic q_ready,
	// fr, pos0, fill, write index, sample_right, sample_left (lowest first)
	input  logic [2*SAMPLE_BITS+3*$clog2(RING_DEPTH)+1+FRACTION_BITS-1:0] q_data,
	output logic m_tvalid,
	input  logic m_tready,
	// tap_left, tap_right, zero pad
	output logic [((2*SAMPLE_BITS+7)/8)*8-1:0] m_tdata
);

	localparam int AB    = $clog2(RING_DEPTH);
	localparam int S     = SAMPLE_BITS;
	localparam int F     = FRACTION_BITS;
	localparam int AW    = SAMPLE_BITS + 6;
	localparam int PW    = AW + FRACTION_BITS + 1;
	localparam int OUT_W = ((2*SAMPLE_BITS+7)/8)*8;

	hfdl_back_state_t state_q, state_d;

	logic [1:0]    cnt_q;
	logic          cnt_inc;
	logic          ram_we;
	logic          issue;
	logic          coef_en;
	logic          mul_en;
	logic          load_out;
	logic          out_free;

	logic [S-1:0]  in_smp [2];
	logic [AB-1:0] in_wi;
	logic [AB:0]   in_fill;
	logic [AB-1:0] in_pos0;
	logic [F-1:0]  in_fr;

	logic [S-1:0]  smp_q [2];
	logic [AB-1:0] wi_q;
	logic [AB:0]   fill_q;
	logic [AB-1:0] pos0_q;
	logic [F-1:0]  fr_q;

	logic [AB-1:0] rd_addr;
	logic          cap_s1;
	logic [1:0]    slot_s1;
	logic          fwd_s1;
	logic          vld_s1;
	logic [S-1:0]  rd_data [2];

	logic [S-1:0]         y_q [2][4];
	logic signed [AW-1:0] a1_q [2];
	logic signed [AW-1:0] a2_q [2];
	logic signed [AW-1:0] t_q [2];
	logic signed [AW-1:0] a1_c [2];
	logic signed [AW-1:0] a2_c [2];
	logic signed [AW-1:0] a3_c [2];
	logic [PW-1:0]        prod [2];
	logic signed [AW-1:0] addend [2];
	logic [AW-1:0]        horner_c [2];
	logic [AW:0]          t_inc [2];
	logic [AW-1:0]        half [2];
	logic [AW:0]          r_c [2];
	logic [S-1:0]         tap_c [2];
	logic [S-1:0]         tap_q [2];
	logic                 m_tvalid_q;

	function automatic logic signed [AW-1:0] ext(input logic [S-1:0] v);
		return {{(AW-S){v[S-1]}}, v};
	endfunction

	assign {in_smp[0], in_smp[1], in_wi, in_fill, in_pos0, in_fr} = q_data;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE:  if (q_valid) state_d = BK_READ;
			BK_READ:  if (cnt_q == 2'd3) state_d = BK_DRAIN;
			BK_DRAIN: state_d = BK_COEF;
			BK_COEF:  state_d = BK_MUL;
			BK_MUL:   if (cnt_q == 2'd2) state_d = BK_DONE;
			BK_DONE:  if (out_free) state_d = BK_IDLE;
			default:  state_d = BK_IDLE;
		endcase
	end

	// Controls for the current state.
	always_comb begin
		q_ready  = 1'b0;
		ram_we   = 1'b0;
		issue    = 1'b0;
		coef_en  = 1'b0;
		mul_en   = 1'b0;
		load_out = 1'b0;
		cnt_inc  = 1'b0;
		unique case (state_q)
			BK_IDLE: q_ready = 1'b1;
			BK_READ: begin
				issue   = 1'b1;
				ram_we  = (cnt_q == 2'd0);
				cnt_inc = (cnt_q != 2'd3);
			end
			BK_DRAIN: ;
			BK_COEF:  coef_en = 1'b1;
			BK_MUL: begin
				mul_en  = 1'b1;
				cnt_inc = (cnt_q != 2'd2);
			end
			BK_DONE:  load_out = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			cnt_q   <= '0;
			cap_s1  <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_inc ? cnt_q + 2'd1 : 2'd0;
			cap_s1  <= issue;
		end
	end

	always_ff @(posedge clk) begin
		if (q_ready && q_valid) begin
			smp_q[0] <= in_smp[0];
			smp_q[1] <= in_smp[1];
			wi_q     <= in_wi;
			fill_q   <= in_fill;
			pos0_q   <= in_pos0;
			fr_q     <= in_fr;
		end
	end

	// Read cycle k fetches neighbour pos0 + k - 1, ym1 first.
	assign rd_addr = pos0_q + AB'(cnt_q) - AB'(1);

	// The slot of this item is forwarded; a slot never written yet reads as zero.
	always_ff @(posedge clk) begin
		slot_s1 <= cnt_q;
		fwd_s1  <= (rd_addr == wi_q);
		vld_s1  <= fill_q[AB] || ({1'b0, rd_addr} < fill_q);
	end

	for (genvar ch = 0; ch < 2; ch++) begin : g_ring
		hfdl_ram #(
			.WIDTH(S),
			.DEPTH(RING_DEPTH)
		) u_ring (
			.clk  (clk),
			.we   (ram_we),
			.waddr(wi_q),
			.wdata(smp_q[ch]),
			.raddr(rd_addr),
			.rdata(rd_data[ch])
		);
	end

	always_comb begin
		for (int ch = 0; ch < 2; ch++) begin
			a1_c[ch] = ext(y_q[ch][2]) - ext(y_q[ch][0]);
			a2_c[ch] = (ext(y_q[ch][0]) <<< 1) - (ext(y_q[ch][1]) <<< 2) - ext(y_q[ch][1])
				+ (ext(y_q[ch][2]) <<< 2) - ext(y_q[ch][3]);
			a3_c[ch] = (ext(y_q[ch][3]) - ext(y_q[ch][0]))
				+ ((ext(y_q[ch][1]) - ext(y_q[ch][2])) <<< 1)
				+ (ext(y_q[ch][1]) - ext(y_q[ch][2]));

			// Low PW bits of the product are exact; dropping F bits is a floor shift.
			prod[ch] = {{(F+1){t_q[ch][AW-1]}}, t_q[ch]} * {{(AW+1){1'b0}}, fr_q};
			if (cnt_q == 2'd0) begin
				addend[ch] = a2_q[ch];
			end else if (cnt_q == 2'd1) begin
				addend[ch] = a1_q[ch];
			end else begin
				addend[ch] = '0;
			end
			horner_c[ch] = prod[ch][AW+F-1:F] + addend[ch];

			// y0 plus half of t, rounded half up, then saturated.
			t_inc[ch] = {t_q[ch][AW-1], t_q[ch]} + (AW+1)'(1);
			half[ch]  = t_inc[ch][AW:1];
			r_c[ch]   = {y_q[ch][1][S-1], ext(y_q[ch][1])} + {half[ch][AW-1], half[ch]};
			if ((&r_c[ch][AW:S-1]) || !(|r_c[ch][AW:S-1])) begin
				tap_c[ch] = r_c[ch][S-1:0];
			end else if (r_c[ch][AW]) begin
				tap_c[ch] = {1'b1, {(S-1){1'b0}}};
			end else begin
				tap_c[ch] = {1'b0, {(S-1){1'b1}}};
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int ch = 0; ch < 2; ch++) begin
			if (cap_s1) begin
				y_q[ch][slot_s1] <= fwd_s1 ? smp_q[ch] : (vld_s1 ? rd_data[ch] : '0);
			end
			if (coef_en) begin
				a1_q[ch] <= a1_c[ch];
				a2_q[ch] <= a2_c[ch];
				t_q[ch]  <= a3_c[ch];
			end else if (mul_en) begin
				t_q[ch] <= horner_c[ch];
			end
			if (load_out) begin
				tap_q[ch] <= tap_c[ch];
			end
		end
	end

	assign out_free = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (load_out) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = OUT_W'({tap_q[1], tap_q[0]});

endmodule

// ===== src/hermite_fractional_delay_line.sv =====
// Stereo fractional delay line with cubic Hermite interpolation, top level.
// Connects hfdl_front, hfdl_queue and hfdl_back; uses hfdl_pkg.
//
// Each input item carries a left and a right sample and a delay in samples with
// FRACTION_BITS fraction bits; the delay is held to between one sample and
// RING_DEPTH-4 samples. The frame is written into two rings and each channel
// returns one Catmull-Rom interpolated tap, saturated to SAMPLE_BITS, as one
// output item. The front end takes an item in any cycle that its two-entry queue
// has room; the back end works on one item at a time: it takes the item from the
// queue, reads the four neighbours on the single read port of each ring, drains
// the registered read, forms the coefficients, runs three Horner steps on one
// multiplier per channel and loads the output register once that is free, and
// only then takes the next item. Slots never written since reset read as zero by
// means of a fill count; there is no clearing pass and the block is ready at once.
module hermite_fractional_delay_line import hfdl_pkg::*; #(
	parameter int RING_DEPTH    = DEF_RING_DEPTH,
	parameter int SAMPLE_BITS   = DEF_SAMPLE_BITS,
	parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// sample_left, sample_right, delay_q16, zero pad
	input  logic [((2*SAMPLE_BITS+DELAY_BITS+7)/8)*8-1:0] s_tdata,
	output logic m_tvalid,
	input  logic m_tready,
	// tap_left, tap_right, zero pad
	output logic [((2*SAMPLE_BITS+7)/8)*8-1:0] m_tdata
);

	localparam int AB = $clog2(RING_DEPTH);
	localparam int QW = 2*SAMPLE_BITS + 3*AB + 1 + FRACTION_BITS;

	logic           fq_valid;
	logic           fq_ready;
	logic [QW-1:0]  fq_data;
	logic           qb_valid;
	logic           qb_ready;
	logic [QW-1:0]  qb_data;
	hfdl_q_status_t q_stat;

	hfdl_front #(
		.RING_DEPTH   (RING_DEPTH),
		.SAMPLE_BITS  (SAMPLE_BITS),
		.FRACTION_BITS(FRACTION_BITS)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.q_valid (fq_valid),
		.q_ready (fq_ready),
		.q_data  (fq_data)
	);

	hfdl_queue #(
		.WIDTH(QW),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (fq_valid),
		.in_ready (fq_ready),
		.in_data  (fq_data),
		.out_valid(qb_valid),
		.out_ready(qb_ready),
		.out_data (qb_data),
		.status   (q_stat)
	);

	hfdl_back #(
		.RING_DEPTH   (RING_DEPTH),
		.SAMPLE_BITS  (SAMPLE_BITS),
		.FRACTION_BITS(FRACTION_BITS)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (qb_valid),
		.q_ready (qb_ready),
		.q_data  (qb_data),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

`ifndef SYNTH
	// Input backpressure comes only from a full queue.
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> q_stat.full)
		else $error("input stalled while the queue has room");

	// An accepted item is waiting in the queue on the next cycle.
	a_push_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !q_stat.empty)
		else $error("accepted item did not reach the queue");

	a_full_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_stat.full |-> !q_stat.empty)
		else $error("queue reports full and empty together");
`endif

endmodule
